// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the accumulator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define PSA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("%m: check failed");

// Consequence that must hold in the cycle after the antecedent
`define PSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- hdl/psa_pkg.sv -----
// Shared constants and types of the progressive sample accumulator
package psa_pkg;

    localparam int C_MAX_WIDTH  = 256;
    localparam int C_MAX_HEIGHT = 256;
    localparam int C_DEPTH      = C_MAX_WIDTH * C_MAX_HEIGHT;
    localparam int C_ADDR_W     = $clog2(C_DEPTH);
    localparam int C_COORD_W    = 8;
    localparam int C_FRAME_W    = 9;
    localparam int C_IDX_W      = 16;
    localparam int C_COLOR_W    = 24;
    localparam int C_ALPHA_W    = 17;
    localparam int C_DEN_W      = C_IDX_W + 1;
    localparam int C_NUM_W      = C_COLOR_W + C_IDX_W;
    localparam int C_REM_W      = C_IDX_W;
    localparam int C_DIV_STAGES = C_COLOR_W;
    localparam int C_OUT_DEPTH  = 32;
    localparam int C_OUT_PTR_W  = $clog2(C_OUT_DEPTH);
    localparam int C_QUEUE_DEPTH = 4;
    localparam int C_QUEUE_PTR_W = $clog2(C_QUEUE_DEPTH);
    localparam int C_CLR_W      = C_ADDR_W + 1;

    localparam logic [C_ALPHA_W-1:0] C_ALPHA_ONE = C_ALPHA_W'(65536);

    localparam int C_CFG_IDX_W  = 2;
    localparam int C_CFG_DATA_W = C_FRAME_W;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_TRANSP = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_WIDTH  = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [C_ADDR_W-1:0]  addr;
        logic                 oor;
        logic                 smart;
        logic                 opaque;
        logic [C_IDX_W-1:0]   idx;
        logic [C_COLOR_W-1:0] red;
        logic [C_COLOR_W-1:0] green;
        logic [C_COLOR_W-1:0] blue;
    } t_cmd;

    typedef struct packed {
        logic [C_COLOR_W-1:0] red;
        logic [C_COLOR_W-1:0] green;
        logic [C_COLOR_W-1:0] blue;
        logic [C_ALPHA_W-1:0] alpha;
    } t_pix;

    typedef struct packed {
        t_pix pix;
        logic oor;
    } t_res;

    typedef struct packed {
        logic                   clearing;
        logic                   issue;
        logic [C_OUT_PTR_W:0]   used;
    } t_back_stat;

endpackage

// ----- hdl/psa_front.sv -----
// Front end: config registers, input beat capture, range check, address
module psa_front import psa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [C_COORD_W-1:0]    i_pixel_x,
    input  logic [C_COORD_W-1:0]    i_pixel_y,
    input  logic [C_IDX_W-1:0]      i_sample_index,
    input  logic [C_COLOR_W-1:0]    i_new_red,
    input  logic [C_COLOR_W-1:0]    i_new_green,
    input  logic [C_COLOR_W-1:0]    i_new_blue,
    input  logic                    i_new_opaque,
    output logic                    o_q_valid,
    input  logic                    i_q_ready,
    output t_cmd                    o_q_cmd
);

    logic                 r_transp;
    logic [C_FRAME_W-1:0] r_fw;
    logic [C_FRAME_W-1:0] r_fh;
    logic                 r_valid;
    t_cmd                 r_cmd;
    t_cmd                 n_cmd;
    logic [C_FRAME_W-1:0] w_sat;
    logic [C_FRAME_W-1:0] h_sat;
    logic [C_ADDR_W:0]    lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transp <= 1'b0;
            r_fw     <= C_FRAME_W'(C_MAX_WIDTH);
            r_fh     <= C_FRAME_W'(C_MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_TRANSP: r_transp <= i_cfg_data[0];
                C_REG_WIDTH:  r_fw     <= i_cfg_data;
                C_REG_HEIGHT: r_fh     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_sat = (r_fw > C_FRAME_W'(C_MAX_WIDTH))  ? C_FRAME_W'(C_MAX_WIDTH)  : r_fw;
        h_sat = (r_fh > C_FRAME_W'(C_MAX_HEIGHT)) ? C_FRAME_W'(C_MAX_HEIGHT) : r_fh;
        lin   = (C_ADDR_W+1)'(i_pixel_y) * (C_ADDR_W+1)'(w_sat) + (C_ADDR_W+1)'(i_pixel_x);
        n_cmd.addr   = lin[C_ADDR_W-1:0];
        n_cmd.oor    = ({1'b0, i_pixel_x} >= w_sat) || ({1'b0, i_pixel_y} >= h_sat);
        n_cmd.smart  = r_transp;
        n_cmd.opaque = i_new_opaque;
        n_cmd.idx    = i_sample_index;
        n_cmd.red    = i_new_red;
        n_cmd.green  = i_new_green;
        n_cmd.blue   = i_new_blue;
    end

    assign o_ready   = !r_valid || i_q_ready;
    assign o_q_valid = r_valid;
    assign o_q_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- hdl/psa_queue.sv -----
// Short command queue between front and back ends
module psa_queue import psa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                   r_mem [C_QUEUE_DEPTH];
    logic [C_QUEUE_PTR_W-1:0] r_wp;
    logic [C_QUEUE_PTR_W-1:0] r_rp;
    logic [C_QUEUE_PTR_W:0]   r_cnt;
    logic                   push_ok;

    assign o_ready = r_cnt != (C_QUEUE_PTR_W+1)'(C_QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];
    assign push_ok = i_push && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_ok, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- hdl/psa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
module psa_div import psa_pkg::*; (
    input  logic                 i_clk,
    input  logic [C_NUM_W-1:0]   i_num,
    input  logic [C_DEN_W-1:0]   i_den,
    output logic [C_COLOR_W-1:0] o_quo
);

    logic [C_NUM_W-1:0] r_acc [C_DIV_STAGES];
    logic [C_DEN_W-1:0] r_den [C_DIV_STAGES];

    // acc holds {partial remainder, numerator bits left, quotient bits so far}
    function automatic logic [C_NUM_W-1:0] div_step(input logic [C_NUM_W-1:0] acc,
                                                    input logic [C_DEN_W-1:0] den);
        logic [C_DEN_W-1:0] t;
        logic [C_DEN_W-1:0] d;
        logic               ge;
        t  = acc[C_NUM_W-1:C_COLOR_W-1];
        ge = t >= den;
        d  = ge ? (t - den) : t;
        return {d[C_REM_W-1:0], acc[C_COLOR_W-2:0], ge};
    endfunction

    always_ff @(posedge i_clk) begin
        r_acc[0] <= div_step(i_num, i_den);
        r_den[0] <= i_den;
        for (int k = 1; k < C_DIV_STAGES; k++) begin
            r_acc[k] <= div_step(r_acc[k-1], r_den[k-1]);
            r_den[k] <= r_den[k-1];
        end
    end

    assign o_quo = r_acc[C_DIV_STAGES-1][C_COLOR_W-1:0];

endmodule

// ----- hdl/psa_back.sv -----
// Back end: pixel store, hazard check, blend math, write back, result queue
module psa_back import psa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res       o_res,
    output t_back_stat o_stat
);

    t_pix                 r_mem [C_DEPTH];
    t_pix                 r_rdata;
    logic [C_CLR_W-1:0]   r_clr;
    logic                 clearing;

    logic                 r1_valid;
    t_cmd                 r1_cmd;

    logic                 rm_valid;
    logic [C_ADDR_W-1:0]  rm_addr;
    logic                 rm_oor;
    logic [C_NUM_W-1:0]   rm_pr, rm_pg, rm_pb, rm_pa;
    logic [C_COLOR_W-1:0] rm_fr, rm_fg, rm_fb;
    logic [C_ALPHA_W-1:0] rm_fa;
    logic [C_DEN_W-1:0]   rm_dc, rm_da;

    logic                 r_cv   [C_DIV_STAGES];
    logic [C_ADDR_W-1:0]  r_caddr [C_DIV_STAGES];
    logic                 r_coor [C_DIV_STAGES];

    t_res                 r_ofifo [C_OUT_DEPTH];
    logic [C_OUT_PTR_W-1:0] r_owp, r_orp;
    logic [C_OUT_PTR_W:0] r_ocnt;
    logic [C_OUT_PTR_W:0] r_used;

    logic                 hit;
    logic                 issue;
    logic                 pop;
    logic                 claim, tclaimed, keep;
    logic [C_IDX_W-1:0]   mc, ma;
    logic [C_COLOR_W-1:0] fr, fg, fb;
    logic [C_ALPHA_W-1:0] fa;
    logic [C_DEN_W-1:0]   np1, dc, da;
    logic [C_COLOR_W-1:0] q_r, q_g, q_b, q_a;
    logic                 wb_valid;
    logic [C_ADDR_W-1:0]  wb_addr;
    logic                 wb_oor;
    t_pix                 wb_pix;
    t_res                 wb_res;

    assign clearing = !r_clr[C_CLR_W-1];

    always_comb begin
        hit = (r1_valid && !r1_cmd.oor && r1_cmd.addr == i_q_cmd.addr)
           || (rm_valid && !rm_oor && rm_addr == i_q_cmd.addr);
        for (int k = 0; k < C_DIV_STAGES; k++) begin
            hit = hit || (r_cv[k] && !r_coor[k] && r_caddr[k] == i_q_cmd.addr);
        end
    end

    assign issue   = i_q_valid && !clearing && !(hit && !i_q_cmd.oor)
                  && (r_used < (C_OUT_PTR_W+1)'(C_OUT_DEPTH));
    assign o_q_pop = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (clearing) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_mem[r_clr[C_ADDR_W-1:0]] <= '0;
        end else if (wb_valid && !wb_oor) begin
            r_mem[wb_addr] <= wb_pix;
        end
        r_rdata <= r_mem[i_q_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        r1_cmd <= i_q_cmd;
    end

    always_comb begin
        np1      = {1'b0, r1_cmd.idx} + 1'b1;
        claim    = r1_cmd.smart && r1_cmd.opaque && r_rdata.alpha == '0;
        tclaimed = r1_cmd.smart && !r1_cmd.opaque && r_rdata.alpha != '0;
        keep     = r1_cmd.smart && !r1_cmd.opaque && r_rdata.alpha == '0;
        if (claim) begin
            mc = '0;  fr = r1_cmd.red; fg = r1_cmd.green; fb = r1_cmd.blue; dc = C_DEN_W'(1);
            ma = '0;  fa = C_ALPHA_ONE; da = np1;
        end else if (tclaimed) begin
            mc = C_IDX_W'(1); fr = '0; fg = '0; fb = '0; dc = C_DEN_W'(1);
            ma = r1_cmd.idx;  fa = '0; da = np1;
        end else if (keep) begin
            mc = C_IDX_W'(1); fr = '0; fg = '0; fb = '0; dc = C_DEN_W'(1);
            ma = C_IDX_W'(1); fa = '0; da = C_DEN_W'(1);
        end else begin
            mc = r1_cmd.idx; fr = r1_cmd.red; fg = r1_cmd.green; fb = r1_cmd.blue; dc = np1;
            ma = r1_cmd.idx; fa = r1_cmd.opaque ? C_ALPHA_ONE : '0; da = np1;
        end
    end

    always_ff @(posedge i_clk) begin
        rm_addr <= r1_cmd.addr;
        rm_oor  <= r1_cmd.oor;
        rm_pr   <= C_NUM_W'(r_rdata.red)   * C_NUM_W'(mc);
        rm_pg   <= C_NUM_W'(r_rdata.green) * C_NUM_W'(mc);
        rm_pb   <= C_NUM_W'(r_rdata.blue)  * C_NUM_W'(mc);
        rm_pa   <= C_NUM_W'(r_rdata.alpha) * C_NUM_W'(ma);
        rm_fr   <= fr;
        rm_fg   <= fg;
        rm_fb   <= fb;
        rm_fa   <= fa;
        rm_dc   <= dc;
        rm_da   <= da;
    end

    psa_div u_div_r (.i_clk(i_clk), .i_num(rm_pr + C_NUM_W'(rm_fr)), .i_den(rm_dc), .o_quo(q_r));
    psa_div u_div_g (.i_clk(i_clk), .i_num(rm_pg + C_NUM_W'(rm_fg)), .i_den(rm_dc), .o_quo(q_g));
    psa_div u_div_b (.i_clk(i_clk), .i_num(rm_pb + C_NUM_W'(rm_fb)), .i_den(rm_dc), .o_quo(q_b));
    psa_div u_div_a (.i_clk(i_clk), .i_num(rm_pa + C_NUM_W'(rm_fa)), .i_den(rm_da), .o_quo(q_a));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            rm_valid <= 1'b0;
            for (int k = 0; k < C_DIV_STAGES; k++) begin
                r_cv[k] <= 1'b0;
            end
        end else begin
            r1_valid <= issue;
            rm_valid <= r1_valid;
            r_cv[0]  <= rm_valid;
            for (int k = 1; k < C_DIV_STAGES; k++) begin
                r_cv[k] <= r_cv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_caddr[0] <= rm_addr;
        r_coor[0]  <= rm_oor;
        for (int k = 1; k < C_DIV_STAGES; k++) begin
            r_caddr[k] <= r_caddr[k-1];
            r_coor[k]  <= r_coor[k-1];
        end
    end

    always_comb begin
        wb_valid     = r_cv[C_DIV_STAGES-1];
        wb_addr      = r_caddr[C_DIV_STAGES-1];
        wb_oor       = r_coor[C_DIV_STAGES-1];
        wb_pix.red   = q_r;
        wb_pix.green = q_g;
        wb_pix.blue  = q_b;
        wb_pix.alpha = q_a[C_ALPHA_W-1:0];
        wb_res.pix   = wb_oor ? '0 : wb_pix;
        wb_res.oor   = wb_oor;
    end

    // result queue; issue credits guarantee a free slot for every beat in flight
    assign o_valid = r_ocnt != '0;
    assign o_res   = r_ofifo[r_orp];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wb_valid) begin
            r_ofifo[r_owp] <= wb_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
            r_used <= '0;
        end else begin
            if (wb_valid) begin
                r_owp <= r_owp + 1'b1;
            end
            if (pop) begin
                r_orp <= r_orp + 1'b1;
            end
            case ({wb_valid, pop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
            case ({issue, pop})
                2'b10:   r_used <= r_used + 1'b1;
                2'b01:   r_used <= r_used - 1'b1;
                default: r_used <= r_used;
            endcase
        end
    end

    always_comb begin
        o_stat.clearing = clearing;
        o_stat.issue    = issue;
        o_stat.used     = r_used;
    end

endmodule

// ----- hdl/progressive_sample_accumulator_unit.sv -----
// A beat passes the front register, command queue, store read, multiply
// register and 24-stage divider. One beat per cycle while result credits
// last; a beat hitting the same pixel as one in flight waits for its write back.
// Reset: synchronous; clears control state, then zeroes the 65536-entry pixel
// store; while it clears no beat is issued (config writes are taken).
`include "assert_macros.svh"
module progressive_sample_accumulator_unit import psa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [C_COORD_W-1:0]    i_pixel_x,
    input  logic [C_COORD_W-1:0]    i_pixel_y,
    input  logic [C_IDX_W-1:0]      i_sample_index,
    input  logic [C_COLOR_W-1:0]    i_new_red,
    input  logic [C_COLOR_W-1:0]    i_new_green,
    input  logic [C_COLOR_W-1:0]    i_new_blue,
    input  logic                    i_new_opaque,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [C_COLOR_W-1:0]    o_out_red,
    output logic [C_COLOR_W-1:0]    o_out_green,
    output logic [C_COLOR_W-1:0]    o_out_blue,
    output logic [C_ALPHA_W-1:0]    o_out_alpha,
    output logic                    o_out_of_range
);

    logic       f_valid;
    logic       q_ready;
    t_cmd       f_cmd;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       q_pop;
    t_res       res;
    t_back_stat stat;

    psa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y), .i_sample_index(i_sample_index),
        .i_new_red(i_new_red), .i_new_green(i_new_green), .i_new_blue(i_new_blue),
        .i_new_opaque(i_new_opaque),
        .o_q_valid(f_valid), .i_q_ready(q_ready), .o_q_cmd(f_cmd)
    );

    psa_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_valid), .i_cmd(f_cmd), .o_ready(q_ready),
        .i_pop(q_pop), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    psa_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_cmd(q_cmd), .o_q_pop(q_pop),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(res), .o_stat(stat)
    );

    assign o_out_red      = res.pix.red;
    assign o_out_green    = res.pix.green;
    assign o_out_blue     = res.pix.blue;
    assign o_out_alpha    = res.pix.alpha;
    assign o_out_of_range = res.oor;

    `PSA_ASSERT_ALWAYS(a_no_issue_clearing, !(stat.clearing && q_pop))
    `PSA_ASSERT_ALWAYS(a_no_result_clearing, !(stat.clearing && o_valid))
    `PSA_ASSERT_ALWAYS(a_credit_bound, stat.used <= (C_OUT_PTR_W+1)'(C_OUT_DEPTH))
    `PSA_ASSERT_NEXT(a_credit_take, stat.issue && !(o_valid && i_ready), stat.used == $past(stat.used) + 1'b1)

endmodule

// ----- verif/tb_top.sv -----
// Testbench for progressive_sample_accumulator_unit: drives samples and checks blended pixels.
module tb_top import psa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [C_COORD_W-1:0] x;
        logic [C_COORD_W-1:0] y;
        logic [C_IDX_W-1:0]   idx;
        logic [C_COLOR_W-1:0] red;
        logic [C_COLOR_W-1:0] green;
        logic [C_COLOR_W-1:0] blue;
        logic                 opaque;
    } sample_t;

    typedef struct {
        logic [C_COLOR_W-1:0] red;
        logic [C_COLOR_W-1:0] green;
        logic [C_COLOR_W-1:0] blue;
        logic [C_ALPHA_W-1:0] alpha;
        logic                 oor;
    } pixel_t;

    class accum_scoreboard;
        logic [C_COLOR_W-1:0] red_acc[C_DEPTH];
        logic [C_COLOR_W-1:0] green_acc[C_DEPTH];
        logic [C_COLOR_W-1:0] blue_acc[C_DEPTH];
        logic [C_ALPHA_W-1:0] alpha_acc[C_DEPTH];
        logic                 smart;
        logic [C_FRAME_W-1:0] width_reg;
        logic [C_FRAME_W-1:0] height_reg;
        pixel_t               pending[$];
        int                   mismatches;

        function new();
            foreach (red_acc[i]) begin
                red_acc[i] = '0;
                green_acc[i] = '0;
                blue_acc[i] = '0;
                alpha_acc[i] = '0;
            end
            smart = 1'b0;
            width_reg = 9'd256;
            height_reg = 9'd256;
            mismatches = 0;
        endfunction

        function void set_reg(logic [C_CFG_IDX_W-1:0] idx, logic [C_CFG_DATA_W-1:0] data);
            case (idx)
                C_REG_TRANSP: smart = data[0];
                C_REG_WIDTH:  width_reg = data;
                C_REG_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function longint unsigned blend(longint unsigned old, longint unsigned n,
                                        longint unsigned fresh);
            return (old * n + fresh) / (n + 1);
        endfunction

        function void note_sample(sample_t s);
            int unsigned w;
            int unsigned h;
            int unsigned a_idx;
            longint unsigned n;
            pixel_t p;
            w = (width_reg > C_MAX_WIDTH) ? C_MAX_WIDTH : width_reg;
            h = (height_reg > C_MAX_HEIGHT) ? C_MAX_HEIGHT : height_reg;
            n = s.idx;
            if (s.x >= w || s.y >= h) begin
                p = '{red: '0, green: '0, blue: '0, alpha: '0, oor: 1'b1};
                pending.push_back(p);
                return;
            end
            a_idx = s.y * w + s.x;
            p.red = red_acc[a_idx];
            p.green = green_acc[a_idx];
            p.blue = blue_acc[a_idx];
            p.alpha = alpha_acc[a_idx];
            p.oor = 1'b0;
            if (smart && s.opaque && p.alpha == 0) begin
                p.red = s.red;
                p.green = s.green;
                p.blue = s.blue;
                p.alpha = C_ALPHA_W'(65536 / (n + 1));
            end else if (smart && !s.opaque && p.alpha != 0) begin
                p.alpha = C_ALPHA_W'(blend(p.alpha, n, 0));
            end else if (!(smart && !s.opaque)) begin
                p.red = C_COLOR_W'(blend(p.red, n, s.red));
                p.green = C_COLOR_W'(blend(p.green, n, s.green));
                p.blue = C_COLOR_W'(blend(p.blue, n, s.blue));
                p.alpha = C_ALPHA_W'(blend(p.alpha, n, s.opaque ? 65536 : 0));
            end
            red_acc[a_idx] = p.red;
            green_acc[a_idx] = p.green;
            blue_acc[a_idx] = p.blue;
            alpha_acc[a_idx] = p.alpha;
            pending.push_back(p);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t exp_p;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: r=%h g=%h b=%h a=%h oor=%b",
                             got.red, got.green, got.blue, got.alpha, got.oor);
                return;
            end
            exp_p = pending.pop_front();
            if (got.red !== exp_p.red || got.green !== exp_p.green ||
                got.blue !== exp_p.blue || got.alpha !== exp_p.alpha ||
                got.oor !== exp_p.oor) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp r=%h g=%h b=%h a=%h oor=%b, got r=%h g=%h b=%h a=%h oor=%b",
                             exp_p.red, exp_p.green, exp_p.blue, exp_p.alpha, exp_p.oor,
                             got.red, got.green, got.blue, got.alpha, got.oor);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [C_CFG_IDX_W-1:0]  i_cfg_idx;
    logic [C_CFG_DATA_W-1:0] i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic [C_COORD_W-1:0]    i_pixel_x;
    logic [C_COORD_W-1:0]    i_pixel_y;
    logic [C_IDX_W-1:0]      i_sample_index;
    logic [C_COLOR_W-1:0]    i_new_red;
    logic [C_COLOR_W-1:0]    i_new_green;
    logic [C_COLOR_W-1:0]    i_new_blue;
    logic                    i_new_opaque;
    logic                    o_valid;
    logic                    i_ready;
    logic [C_COLOR_W-1:0]    o_out_red;
    logic [C_COLOR_W-1:0]    o_out_green;
    logic [C_COLOR_W-1:0]    o_out_blue;
    logic [C_ALPHA_W-1:0]    o_out_alpha;
    logic                    o_out_of_range;

    progressive_sample_accumulator_unit dut (.*);

    accum_scoreboard sb = new();
    int send_idle_pct = 27;
    int recv_idle_pct = 51;
    int sent = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20_000_000;
        $display("progressive_sample_accumulator_unit verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_pixel('{red: o_out_red, green: o_out_green, blue: o_out_blue,
                             alpha: o_out_alpha, oor: o_out_of_range});
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_frame(logic smart, logic [C_FRAME_W-1:0] w, logic [C_FRAME_W-1:0] h);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= C_REG_TRANSP;
        i_cfg_data <= {8'h00, smart};
        @(posedge i_clk);
        sb.set_reg(C_REG_TRANSP, {8'h00, smart});
        i_cfg_idx <= C_REG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        sb.set_reg(C_REG_WIDTH, w);
        i_cfg_idx <= C_REG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        sb.set_reg(C_REG_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(sample_t s);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_x <= s.x;
        i_pixel_y <= s.y;
        i_sample_index <= s.idx;
        i_new_red <= s.red;
        i_new_green <= s.green;
        i_new_blue <= s.blue;
        i_new_opaque <= s.opaque;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(s);
        sent++;
        if (sent == 200) begin
            send_idle_pct = 51;
            recv_idle_pct = 27;
        end else if (sent == 400) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // pause the sender until every pending pixel is back, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [C_COLOR_W-1:0] rand_color();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return C_COLOR_W'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count, int unsigned w, int unsigned h);
        logic [C_COORD_W-1:0] px[6];
        logic [C_COORD_W-1:0] py[6];
        int unsigned passes[6];
        sample_t s;
        int k;
        foreach (px[i]) begin
            px[i] = (w == 0) ? C_COORD_W'($urandom) : C_COORD_W'($urandom_range(w - 1));
            py[i] = (h == 0) ? C_COORD_W'($urandom) : C_COORD_W'($urandom_range(h - 1));
            passes[i] = 0;
        end
        repeat (count) begin
            s.red = rand_color();
            s.green = rand_color();
            s.blue = rand_color();
            s.opaque = ($urandom_range(99) < 65);
            if ($urandom_range(99) < 80) begin
                k = $urandom_range(5);
                s.x = px[k];
                s.y = py[k];
                s.idx = C_IDX_W'(passes[k]);
                passes[k]++;
            end else begin
                s.x = C_COORD_W'($urandom);
                s.y = C_COORD_W'($urandom);
                s.idx = ($urandom_range(3) == 0) ? 16'hFFFF : C_IDX_W'($urandom);
            end
            send_sample(s);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= C_REG_TRANSP;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_pixel_x <= '0;
        i_pixel_y <= '0;
        i_sample_index <= '0;
        i_new_red <= '0;
        i_new_green <= '0;
        i_new_blue <= '0;
        i_new_opaque <= 1'b0;
        i_ready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smart and plain blend cases, field extremes and range checks on full and small frames
        write_frame(1'b1, 9'd256, 9'd256);
        send_sample('{8'd0, 8'd0, 16'd0, '1, '1, '1, 1'b0});
        send_sample('{8'd0, 8'd0, 16'd3, '1, '0, '1, 1'b1});
        send_sample('{8'd0, 8'd0, 16'd4, '0, '1, '0, 1'b0});
        send_sample('{8'd0, 8'd0, 16'd5, '1, '1, '1, 1'b1});
        send_sample('{8'd0, 8'd0, 16'hFFFF, '0, '0, '0, 1'b0});
        send_sample('{8'd255, 8'd255, 16'd0, '1, '1, '1, 1'b1});
        send_sample('{8'd255, 8'd255, 16'd1, '0, '0, '0, 1'b1});
        send_sample('{8'd255, 8'd255, 16'hFFFF, '1, '1, '1, 1'b1});
        send_sample('{8'd255, 8'd0, 16'hFFFF, '1, '1, '1, 1'b1});
        send_sample('{8'd0, 8'd255, 16'd1, 24'h123456, 24'hABCDEF, 24'h800000, 1'b0});
        drain();
        write_frame(1'b0, 9'd256, 9'd256);
        send_sample('{8'd1, 8'd1, 16'd0, 24'h00FFFF, 24'h010000, 24'hFF0000, 1'b0});
        send_sample('{8'd1, 8'd1, 16'd1, '1, '1, '1, 1'b1});
        send_sample('{8'd1, 8'd1, 16'hFFFF, '0, '0, '0, 1'b1});
        send_sample('{8'd0, 8'd0, 16'd6, '1, '1, '1, 1'b0});
        drain();
        write_frame(1'b1, 9'd4, 9'd3);
        send_sample('{8'd4, 8'd0, 16'd0, '1, '1, '1, 1'b1});
        send_sample('{8'd0, 8'd3, 16'd0, '1, '1, '1, 1'b1});
        send_sample('{8'd3, 8'd2, 16'd0, '1, '1, '1, 1'b1});
        send_sample('{8'd255, 8'd255, 16'd0, '1, '1, '1, 1'b0});
        drain();

        random_phase(90, 256, 256);
        drain();
        write_frame(1'b1, 9'd16, 9'd8);
        random_phase(90, 16, 8);
        drain();
        write_frame(1'b0, 9'd1, 9'd1);
        random_phase(80, 1, 1);
        drain();
        write_frame(1'b1, 9'd511, 9'd300);
        random_phase(90, 256, 256);
        drain();
        write_frame(1'b0, 9'd0, 9'd5);
        random_phase(40, 0, 5);
        drain();
        write_frame(1'b1, 9'd7, 9'd0);
        random_phase(40, 7, 0);
        drain();
        write_frame(1'b1, 9'd3, 9'd200);
        random_phase(90, 3, 200);
        drain();
        write_frame(1'b0, 9'd256, 9'd1);
        random_phase(80, 256, 1);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("progressive_sample_accumulator_unit verification clean");
        else
            $display("progressive_sample_accumulator_unit verification failed");
        $finish;
    end
endmodule
